/* sv/xorshift_range_random_macros.svh */
// Assertion macros shared by the xorshift range random block.
`ifndef XORSHIFT_RANGE_RANDOM_MACROS_SVH
`define XORSHIFT_RANGE_RANDOM_MACROS_SVH
`ifndef ASSERT_OFF
`define XRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XRR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define XRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define XRR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/xrr_pkg.sv */
// Types, constants and command structs of the xorshift range random block.
`default_nettype none
package xrr_pkg;

    localparam int SHL_A        = 21;
    localparam int SHR_B        = 35;
    localparam int SHL_C        = 4;
    localparam int STATE_W      = 64;
    localparam int WORD_W       = 32;
    localparam int VAL_W        = 31;
    localparam int MAX_ATTEMPTS = 64;
    localparam int TRY_W        = $clog2(MAX_ATTEMPTS);
    localparam int BIT_W        = $clog2(WORD_W);

    localparam logic [1:0] KIND_VALUE = 2'd0;
    localparam logic [1:0] KIND_ZERO  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [WORD_W-1:0]  seed_value;
        logic        [WORD_W-1:0]  time_now;
        logic signed [WORD_W-1:0]  range_min;
        logic signed [WORD_W-1:0]  range_max;
    } t_in;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             range_error;
    } t_out;

    typedef struct packed {
        logic       load;
        logic       seed;
        logic       step;
        logic       div;
        logic       out_load;
        logic [1:0] out_kind;
    } t_cmd;

    typedef struct packed {
        logic mode;
        logic range_bad;
        logic hit;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

/* sv/xrr_datapath.sv */
// Datapath: generator state, request registers, serial remainder and result register.
`default_nettype none
module xrr_datapath (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire xrr_pkg::t_in    i_in_data,
    input  wire xrr_pkg::t_cmd   i_cmd,
    output xrr_pkg::t_status     o_status,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output xrr_pkg::t_out        o_out_data
);
    import xrr_pkg::*;

    function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] s_in);
        logic [STATE_W-1:0] s;
        s = s_in;
        s = s ^ (s << SHL_A);
        s = s ^ {{SHR_B{s[STATE_W-1]}}, s[STATE_W-1:SHR_B]};
        s = s ^ (s << SHL_C);
        return s;
    endfunction

    logic [STATE_W-1:0] r_state, n_state;
    logic               r_seeded;
    logic               r_mode;
    logic [WORD_W-1:0]  r_seed;
    logic [WORD_W-1:0]  r_now;
    logic [VAL_W-1:0]   r_rmin;
    logic [VAL_W-1:0]   r_mod;
    logic               r_reseed;
    logic [WORD_W-1:0]  r_dvd;
    logic [VAL_W-1:0]   r_rem;
    logic               r_out_valid;
    t_out               r_out;

    logic [STATE_W-1:0] base;
    logic [WORD_W-1:0]  low;
    logic [WORD_W-1:0]  mag;
    logic [WORD_W-1:0]  rem_sh;
    logic [WORD_W-1:0]  mod_ext;
    logic [VAL_W-1:0]   in_rmin;
    logic [VAL_W-1:0]   in_mod;

    always_comb begin
        in_rmin = i_in_data.range_min[WORD_W-1] ? '0 : i_in_data.range_min[VAL_W-1:0];
        if (!i_in_data.range_max[WORD_W-1] && (i_in_data.range_max[VAL_W-1:0] != '1)) begin
            in_mod = i_in_data.range_max[VAL_W-1:0] + VAL_W'(1);
        end else begin
            in_mod = VAL_W'(1);
        end
    end

    always_comb begin
        base    = (r_reseed || !r_seeded) ? {{(STATE_W-WORD_W){1'b0}}, r_now} : r_state;
        n_state = advance(base);
        low     = n_state[WORD_W-1:0];
        mag     = low[WORD_W-1] ? (~low + WORD_W'(1)) : low;
        mod_ext = {1'b0, r_mod};
        rem_sh  = {r_rem, r_dvd[WORD_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= '0;
            r_seeded <= 1'b0;
        end else if (i_cmd.seed) begin
            r_state  <= {{(STATE_W-WORD_W){1'b0}}, r_now}
                        + {{(STATE_W-WORD_W){r_seed[WORD_W-1]}}, r_seed};
            r_seeded <= 1'b1;
        end else if (i_cmd.step) begin
            r_state  <= n_state;
            r_seeded <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode   <= i_in_data.mode;
            r_seed   <= i_in_data.seed_value;
            r_now    <= i_in_data.time_now;
            r_rmin   <= in_rmin;
            r_mod    <= in_mod;
            r_reseed <= (i_in_data.range_max == '1);
        end
        if (i_cmd.step) begin
            r_dvd <= mag;
            r_rem <= '0;
        end else if (i_cmd.div) begin
            r_dvd <= {r_dvd[WORD_W-2:0], 1'b0};
            if (rem_sh >= mod_ext) begin
                r_rem <= VAL_W'(rem_sh - mod_ext);
            end else begin
                r_rem <= rem_sh[VAL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_kind)
                KIND_VALUE: begin
                    r_out.value       <= r_rem;
                    r_out.range_error <= 1'b0;
                end
                KIND_ERROR: begin
                    r_out.value       <= '0;
                    r_out.range_error <= 1'b1;
                end
                default: begin
                    r_out.value       <= '0;
                    r_out.range_error <= 1'b0;
                end
            endcase
        end
    end

    assign o_status.mode      = r_mode;
    assign o_status.range_bad = (r_rmin >= r_mod);
    assign o_status.hit       = (r_rem >= r_rmin);
    assign o_status.out_busy  = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule
`default_nettype wire

/* sv/xrr_controller.sv */
// Controller: sequences seeding, generator steps, remainder bits and retries.
`default_nettype none
`include "xorshift_range_random_macros.svh"
module xrr_controller (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire xrr_pkg::t_status  i_status,
    output xrr_pkg::t_cmd          o_cmd
);
    import xrr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_STEP   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_W - 1);
    localparam logic [TRY_W-1:0] TRY_LAST = TRY_W'(MAX_ATTEMPTS - 1);

    logic [2:0]       r_state, n_state;
    logic [BIT_W-1:0] r_bit, n_bit;
    logic [TRY_W-1:0] r_try, n_try;
    logic [1:0]       r_kind, n_kind;

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        n_try   = r_try;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.out_kind = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_try = '0;
                if (i_status.mode) begin
                    o_cmd.seed = 1'b1;
                    n_kind     = KIND_ZERO;
                    n_state    = S_FINISH;
                end else if (i_status.range_bad) begin
                    n_kind  = KIND_ERROR;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_bit      = '0;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (r_bit == BIT_LAST) begin
                    n_state = S_CHECK;
                end else begin
                    n_bit = r_bit + BIT_W'(1);
                end
            end
            S_CHECK: begin
                if (i_status.hit) begin
                    n_kind  = KIND_VALUE;
                    n_state = S_FINISH;
                end else if (r_try == TRY_LAST) begin
                    n_kind  = KIND_ERROR;
                    n_state = S_FINISH;
                end else begin
                    n_try   = r_try + TRY_W'(1);
                    n_state = S_STEP;
                end
            end
            S_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bit  <= n_bit;
        r_try  <= n_try;
        r_kind <= n_kind;
    end

    assign o_in_ready = (r_state == S_IDLE) && i_rst_n;

    `XRR_ASSERT(a_out_free, i_clk, i_rst_n, o_cmd.out_load |-> !i_status.out_busy, "result overwritten")
    `XRR_ASSERT(a_accept_decide, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> (r_state == S_DECIDE), "accepted transfer not decoded")
    `XRR_ASSERT(a_check_after_div, i_clk, i_rst_n, (r_state == S_CHECK) |-> ($past(r_state) == S_DIV && $past(r_bit) == BIT_LAST), "check before remainder finished")
    `XRR_ASSERT(a_step_origin, i_clk, i_rst_n, (r_state == S_STEP) |-> ($past(r_state) == S_DECIDE || $past(r_state) == S_CHECK), "step from wrong state")

endmodule
`default_nettype wire

/* sv/xorshift_range_random.sv */
// Top level of the xorshift range random block.
`default_nettype none
// A seed transfer loads the 64-bit generator state with time plus the signed seed and
// returns a zero result. A draw transfer runs one or more attempts: each advances the
// xorshift state, runs the bit-serial remainder of the low word's magnitude against the
// modulus, and checks the result against the minimum. After at most 64 attempts without
// a hit the range error flag is returned; an impossible range returns the error without
// any attempt. The next transfer is taken after a result is loaded. One transfer is in
// work at a time, and a new one is taken while the previous result waits in the output
// register; the block stalls before loading its result until the waiting one is taken.
module xorshift_range_random (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire xrr_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output xrr_pkg::t_out       o_out_data
);
    import xrr_pkg::*;

    t_cmd    cmd;
    t_status status;

    xrr_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    xrr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the xorshift range random block, with random traffic and a built-in predictor.
module tb_top;

    localparam logic MODE_DRAW  = 1'b0;
    localparam logic MODE_SEED  = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   RAND_ITEMS = 900;

    logic          i_clk;
    logic          i_rst_n    = 1'b0;
    logic          i_in_valid = 1'b0;
    logic          o_in_ready;
    xrr_pkg::t_in  i_in_data  = '0;
    logic          o_out_valid;
    logic          i_out_ready = 1'b0;
    xrr_pkg::t_out o_out_data;

    xrr_pkg::t_in  pending_reqs[$];
    xrr_pkg::t_out expected_results[$];
    xrr_pkg::t_out oldest_result;

    logic [63:0] xs_state  = '0;
    bit          xs_seeded = 1'b0;
    int          mismatches = 0;

    xorshift_range_random uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [63:0] xs_advance(logic [63:0] s);
        logic signed [63:0] sx;
        s = s ^ (s << xrr_pkg::SHL_A);
        sx = s;
        sx = sx >>> xrr_pkg::SHR_B;
        s = s ^ sx;
        s = s ^ (s << xrr_pkg::SHL_C);
        return s;
    endfunction

    function automatic xrr_pkg::t_out predict_result(xrr_pkg::t_in req);
        xrr_pkg::t_out res;
        longint        lo_bound;
        longint        hi_bound;
        longint        modulus;
        longint        picked;
        logic [31:0]   low_word;
        logic [31:0]   magnitude;
        logic [31:0]   remainder;
        int            k;
        res = '0;
        if (req.mode == MODE_SEED) begin
            xs_state  = {32'b0, req.time_now} + {{32{req.seed_value[31]}}, req.seed_value};
            xs_seeded = 1'b1;
            return res;
        end
        lo_bound = longint'($signed(req.range_min));
        hi_bound = longint'($signed(req.range_max));
        if (lo_bound < 0) begin
            lo_bound = 0;
        end
        modulus = hi_bound + 1;
        if (modulus <= 0 || modulus > 2147483647) begin
            modulus = 1;
        end
        if (lo_bound >= modulus) begin
            res.range_error = 1'b1;
            return res;
        end
        for (k = 0; k < xrr_pkg::MAX_ATTEMPTS; k++) begin
            if (hi_bound == -1) begin
                xs_seeded = 1'b0;
            end
            if (!xs_seeded) begin
                xs_state  = {32'b0, req.time_now};
                xs_seeded = 1'b1;
            end
            xs_state  = xs_advance(xs_state);
            low_word  = xs_state[31:0];
            magnitude = low_word[31] ? (32'd0 - low_word) : low_word;
            remainder = magnitude % modulus[31:0];
            picked    = {32'b0, remainder};
            if (picked >= lo_bound) begin
                res.value = remainder[30:0];
                return res;
            end
        end
        res.range_error = 1'b1;
        return res;
    endfunction

    // Solves over GF(2) for a 32-bit start state whose low word becomes the most
    // negative value after a number of generator steps.
    function automatic logic [31:0] find_min_word_seed(output int steps);
        logic [31:0] piv_vec[32];
        logic [31:0] piv_comb[32];
        bit          piv_used[32];
        logic [63:0] probe;
        logic [31:0] col;
        logic [31:0] comb;
        logic [31:0] target;
        logic [31:0] sol;
        int          n;
        int          j;
        int          p;
        int          k;
        steps = 0;
        for (n = 1; n <= 8; n++) begin
            for (p = 0; p < 32; p++) begin
                piv_used[p] = 1'b0;
            end
            for (j = 0; j < 32; j++) begin
                probe = 64'd1 << j;
                for (k = 0; k < n; k++) begin
                    probe = xs_advance(probe);
                end
                col  = probe[31:0];
                comb = 32'd1 << j;
                for (p = 31; p >= 0; p--) begin
                    if (col[p]) begin
                        if (piv_used[p]) begin
                            col  = col ^ piv_vec[p];
                            comb = comb ^ piv_comb[p];
                        end else begin
                            piv_vec[p]  = col;
                            piv_comb[p] = comb;
                            piv_used[p] = 1'b1;
                            break;
                        end
                    end
                end
            end
            target = 32'h8000_0000;
            sol    = '0;
            for (p = 31; p >= 0; p--) begin
                if (target[p] && piv_used[p]) begin
                    target = target ^ piv_vec[p];
                    sol    = sol ^ piv_comb[p];
                end
            end
            if (target == '0) begin
                steps = n;
                return sol;
            end
        end
        return '0;
    endfunction

    task automatic add_seed(logic [31:0] t, logic [31:0] sv);
        xrr_pkg::t_in req;
        req.mode       = MODE_SEED;
        req.seed_value = sv;
        req.time_now   = t;
        req.range_min  = $urandom();
        req.range_max  = $urandom();
        pending_reqs.push_back(req);
    endtask

    task automatic add_draw(logic [31:0] t, logic [31:0] lo, logic [31:0] hi);
        xrr_pkg::t_in req;
        req.mode       = MODE_DRAW;
        req.seed_value = $urandom();
        req.time_now   = t;
        req.range_min  = lo;
        req.range_max  = hi;
        pending_reqs.push_back(req);
    endtask

    // Sender: bursts of transfers separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready) begin
            if (i_in_valid) begin
                expected_results.push_back(predict_result(i_in_data));
            end
            if (gap_left > 0 || pending_reqs.size() == 0) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                i_in_valid <= 1'b0;
            end else begin
                i_in_data  <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(40, 1);
                    gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(15, 1);
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus two long hold-offs that back up the block.
    int rx_hold       = 0;
    int rx_mode       = 0;
    int rx_phase      = 0;
    int rx_taken      = 0;
    int rx_holds_done = 0;
    bit rx_take;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                rx_taken++;
            end
            if (rx_hold > 0) begin
                rx_hold--;
            end else if ((rx_holds_done == 0 && rx_taken >= 60) ||
                         (rx_holds_done == 1 && rx_taken >= 500)) begin
                rx_hold = 600;
                rx_holds_done++;
            end
            if (rx_phase == 0) begin
                rx_mode  = $urandom_range(3);
                rx_phase = $urandom_range(300, 40);
            end else begin
                rx_phase--;
            end
            case (rx_mode)
                0: begin
                    rx_take = 1'b1;
                end
                1: begin
                    rx_take = $urandom_range(1);
                end
                2: begin
                    rx_take = ($urandom_range(4) == 0);
                end
                default: begin
                    rx_take = (rx_phase % 7) < 4;
                end
            endcase
            i_out_ready <= (rx_hold == 0) && rx_take;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value=%0d error=%0b",
                         $time, o_out_data.value, o_out_data.range_error);
                mismatches++;
            end else begin
                oldest_result = expected_results.pop_front();
                if (o_out_data.value !== oldest_result.value) begin
                    $display("%0t: value mismatch, expected %0d, actual %0d",
                             $time, oldest_result.value, o_out_data.value);
                    mismatches++;
                end
                if (o_out_data.range_error !== oldest_result.range_error) begin
                    $display("%0t: range_error mismatch, expected %0b, actual %0b",
                             $time, oldest_result.range_error, o_out_data.range_error);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (pending_reqs.size() == 0 && !i_in_valid && expected_results.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int          i;
        int          k;
        int          sel;
        int          steps;
        logic [31:0] t;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] sv;
        logic [31:0] word_seed;

        // Directed part: unseeded start, range extremes, impossible ranges,
        // stuck zero state and the most negative low word.
        add_draw(32'd0, 32'd0, 32'd10);
        add_draw(32'd0, 32'd5, 32'd10);
        add_draw(32'd0, 32'd0, 32'hFFFF_FFFF);
        add_seed(32'hFFFF_FFFF, 32'h8000_0000);
        add_draw($urandom(), 32'h8000_0000, 32'h7FFF_FFFE);
        add_draw($urandom(), 32'd0, 32'h7FFF_FFFF);
        add_draw($urandom(), 32'd1, 32'h7FFF_FFFF);
        add_draw($urandom(), 32'd0, 32'h8000_0000);
        add_draw($urandom(), 32'h7FFF_FFFF, 32'h7FFF_FFFE);
        add_draw($urandom(), 32'd10, 32'd5);
        add_draw(32'd12345, 32'd0, 32'hFFFF_FFFF);
        add_draw(32'd12345, 32'd1, 32'hFFFF_FFFF);
        add_seed(32'd0, 32'hFFFF_FFFF);
        add_draw($urandom(), 32'd7, 32'd7);
        add_draw($urandom(), 32'd0, 32'd0);
        add_seed(32'd100, -32'sd100);
        add_draw($urandom(), 32'd3, 32'd9);
        word_seed = find_min_word_seed(steps);
        if (steps > 0) begin
            add_seed(word_seed, 32'd0);
            for (k = 0; k < steps; k++) begin
                add_draw($urandom(), 32'd0, 32'h7FFF_FFFE);
            end
        end
        add_seed(32'd0, 32'h7FFF_FFFF);

        for (i = 0; i < RAND_ITEMS; i++) begin
            sel = $urandom_range(99);
            if (sel < 8) begin
                t   = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 32'd0 : 32'hFFFF_FFFF)
                                                : $urandom();
                sv  = ($urandom_range(4) == 0) ? (32'd0 - t) : $urandom();
                add_seed(t, sv);
            end else begin
                t   = ($urandom_range(19) == 0) ? 32'd0 : $urandom();
                sel = $urandom_range(99);
                if (sel < 35) begin
                    hi = $urandom_range(20);
                end else if (sel < 55) begin
                    hi = $urandom_range(5000);
                end else if (sel < 70) begin
                    hi = $urandom();
                end else if (sel < 76) begin
                    hi = 32'hFFFF_FFFF;
                end else if (sel < 82) begin
                    hi = 32'h7FFF_FFFF;
                end else if (sel < 88) begin
                    hi = 32'h7FFF_FFFE;
                end else begin
                    hi = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
                end
                sel = $urandom_range(99);
                if (sel < 45) begin
                    lo = 32'd0;
                end else if (sel < 60) begin
                    lo = $urandom() | 32'h8000_0000;
                end else if (sel < 85) begin
                    lo = hi[31] ? 32'd0 : $urandom_range(hi, 0);
                end else if (sel < 93) begin
                    lo = hi + $urandom_range(3, 1);
                end else begin
                    lo = $urandom();
                end
                add_draw(t, lo, hi);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/xrr_pkg.sv
sv/xrr_datapath.sv
sv/xrr_controller.sv
sv/xorshift_range_random.sv
tb/tb_top.sv
